// File: hw/rtl/pitp_pkg.sv
package pitp_pkg;

	localparam int unsigned OUT_WIDTH = 64;
	localparam int unsigned REG_WIDTH = 64;
	localparam int unsigned BASE_WIDTH = 6;

	localparam logic [2:0] PH_DONE     = 3'd0;
	localparam logic [2:0] PH_LEAD     = 3'd1;
	localparam logic [2:0] PH_SIGNED   = 3'd2;
	localparam logic [2:0] PH_ZERO     = 3'd3;
	localparam logic [2:0] PH_PREFIXED = 3'd4;
	localparam logic [2:0] PH_DIGITS   = 3'd5;

	localparam logic [0:0] REG_DEFAULT_VALUE = 1'b0;
	localparam logic [0:0] REG_NUMBER_BASE   = 1'b1;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_B  = 8'h42;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_UC_O  = 8'h4F;
	localparam logic [7:0] CH_LC_O  = 8'h6F;

	// 'A' - '9' - 1 and 'a' - '9' - 1
	localparam logic [7:0] UC_LETTER_OFS = 8'd7;
	localparam logic [7:0] LC_LETTER_OFS = 8'd39;

	localparam logic [BASE_WIDTH-1:0] BASE_HEX = 6'd16;
	localparam logic [BASE_WIDTH-1:0] BASE_BIN = 6'd2;
	localparam logic [BASE_WIDTH-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_WIDTH-1:0] BASE_DEC = 6'd10;

endpackage

// File: hw/rtl/prefixed_integer_text_parser.sv
// A result beat is registered in the output stage from the input-stage byte that ends the number.
// Throughput: one byte per cycle while no result waits; a digit step is one 64x6 multiply-add.
// While a result waits, one more byte is taken into the input stage, then s_tready drops.
// Reset (arst_n low): parser waits for a first byte, registers clear to zero, no beats pending.
module prefixed_integer_text_parser #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] parsed_value
	output logic        m_tuser,   // [0] used_default
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);
	import pitp_pkg::*;

	logic [REG_WIDTH-1:0]  default_value_q;
	logic [BASE_WIDTH-1:0] number_base_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	logic [2:0]             phase_q;
	logic                   neg_q;
	logic [BASE_WIDTH-1:0]  base_q;
	logic [VALUE_WIDTH-1:0] acc_q;

	logic adv;
	logic fire;

	logic [2:0]             ph;
	logic                   neg;
	logic [BASE_WIDTH-1:0]  base;
	logic [VALUE_WIDTH-1:0] acc;

	logic [2:0]             nph;
	logic                   nneg;
	logic [BASE_WIDTH-1:0]  nbase;
	logic [VALUE_WIDTH-1:0] nacc;
	logic                   emit_val;
	logic                   emit_def;
	logic                   digit_go;
	logic [BASE_WIDTH-1:0]  wb;
	logic [BASE_WIDTH-1:0]  base_or_dec;
	logic [BASE_WIDTH-1:0]  base_or_oct;

	logic [7:0]             dmap;
	logic [7:0]             dval;
	logic                   dlegal;
	logic [VALUE_WIDTH-1:0] acc_step;
	logic signed [VALUE_WIDTH-1:0] sval;

	assign adv      = !m_tvalid || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_value_q <= '0;
			number_base_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEFAULT_VALUE: default_value_q <= cfg_wdata;
				REG_NUMBER_BASE:   number_base_q   <= cfg_wdata[BASE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	assign ph   = first_s1 ? PH_LEAD : phase_q;
	assign neg  = first_s1 ? 1'b0 : neg_q;
	assign base = first_s1 ? '0 : base_q;
	assign acc  = first_s1 ? '0 : acc_q;

	assign base_or_dec = (number_base_q != '0) ? number_base_q : BASE_DEC;
	assign base_or_oct = (number_base_q != '0) ? number_base_q : BASE_OCT;

	always_comb begin
		nph      = ph;
		nneg     = neg;
		nbase    = base;
		emit_val = 1'b0;
		emit_def = 1'b0;
		digit_go = 1'b0;
		wb       = base;
		unique case (ph)
			PH_LEAD, PH_SIGNED: begin
				if (ph == PH_LEAD && (byte_s1 == CH_SPACE || byte_s1 == CH_TAB)) begin
					nph = PH_LEAD;
				end else if (ph == PH_LEAD && byte_s1 < CH_SPACE) begin
					emit_def = 1'b1;
				end else if (ph == PH_LEAD && byte_s1 == CH_MINUS) begin
					nneg = 1'b1;
					nph  = PH_SIGNED;
				end else if (ph == PH_LEAD && byte_s1 == CH_PLUS) begin
					nph = PH_SIGNED;
				end else if (byte_s1 < CH_ZERO) begin
					emit_def = 1'b1;
				end else if (byte_s1 == CH_ZERO) begin
					nph = PH_ZERO;
				end else begin
					wb       = base_or_dec;
					nbase    = base_or_dec;
					digit_go = 1'b1;
				end
			end
			PH_ZERO: begin
				if (byte_s1 < CH_ZERO) begin
					emit_val = 1'b1;
				end else if (byte_s1 == CH_LC_X || byte_s1 == CH_UC_X) begin
					nbase = BASE_HEX;
					nph   = PH_PREFIXED;
				end else if (byte_s1 == CH_LC_B || byte_s1 == CH_UC_B) begin
					nbase = BASE_BIN;
					nph   = PH_PREFIXED;
				end else if (byte_s1 == CH_LC_O || byte_s1 == CH_UC_O) begin
					nbase = BASE_OCT;
					nph   = PH_PREFIXED;
				end else begin
					wb       = base_or_oct;
					nbase    = base_or_oct;
					digit_go = 1'b1;
				end
			end
			PH_PREFIXED: begin
				if (byte_s1 < CH_ZERO) begin
					emit_def = 1'b1;
				end else begin
					digit_go = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (byte_s1 < CH_ZERO) begin
					emit_val = 1'b1;
				end else begin
					digit_go = 1'b1;
				end
			end
			default: begin
				nph = PH_DONE;
			end
		endcase
		if (digit_go) begin
			if (dlegal) begin
				nph = PH_DIGITS;
			end else begin
				emit_def = 1'b1;
			end
		end
		if (emit_val || emit_def) begin
			nph = PH_DONE;
		end
	end

	always_comb begin
		dmap = byte_s1;
		if (wb > BASE_DEC) begin
			if (byte_s1 >= CH_UC_A && byte_s1 <= CH_UC_Z) begin
				dmap = byte_s1 - UC_LETTER_OFS;
			end else if (byte_s1 >= CH_LC_A && byte_s1 <= CH_LC_Z) begin
				dmap = byte_s1 - LC_LETTER_OFS;
			end
		end
	end

	assign dval     = dmap - CH_ZERO;
	assign dlegal   = dval < {{(8-BASE_WIDTH){1'b0}}, wb};
	assign acc_step = acc * VALUE_WIDTH'(wb) + VALUE_WIDTH'(dval);
	assign nacc     = (digit_go && dlegal) ? acc_step : acc;

	// lone zero leaves the accumulator at zero, so one negate path covers both
	assign sval = neg ? VALUE_WIDTH'(-acc) : acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
		end else if (fire) begin
			phase_q <= nph;
			neg_q   <= nneg;
			base_q  <= nbase;
			acc_q   <= nacc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= valid_s1 && (emit_val || emit_def);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (emit_val || emit_def)) begin
			m_tdata <= emit_def ? default_value_q : OUT_WIDTH'(sval);
			m_tuser <= emit_def;
		end
	end

endmodule

// File: tb/sv/prefixed_integer_text_parser_test.sv
module prefixed_integer_text_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pitp_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} text_beat_t;

	typedef struct packed {
		logic [63:0] value;
		logic        dflt;
	} number_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [63:0] cfg_wdata = '0;

	prefixed_integer_text_parser uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	text_beat_t pending_text[$];
	number_t    awaited_numbers[$];
	int         fail_count = 0;

	// register shadows
	logic [63:0]           cfg_default = '0;
	logic [BASE_WIDTH-1:0] cfg_base = '0;

	// parser shadow state
	logic [2:0]            sc_phase = PH_DONE;
	logic                  sc_neg = 1'b0;
	logic [BASE_WIDTH-1:0] sc_base = '0;
	logic [63:0]           sc_acc = '0;

	logic        tx_hold = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned rx_tick = 0;
	int unsigned rx_mode = 0;
	bit          string_open = 0;

	task automatic give_number(input logic [63:0] v, input logic dflt);
		number_t n;
		n.value = v;
		n.dflt = dflt;
		awaited_numbers.push_back(n);
		sc_phase = PH_DONE;
	endtask

	task automatic close_number();
		give_number(sc_neg ? -sc_acc : sc_acc, 1'b0);
	endtask

	task automatic take_digit(input logic [7:0] c);
		logic [7:0] d;
		d = c;
		if (sc_base > BASE_DEC) begin
			if (c >= CH_UC_A && c <= CH_UC_Z)
				d = c - UC_LETTER_OFS;
			else if (c >= CH_LC_A && c <= CH_LC_Z)
				d = c - LC_LETTER_OFS;
		end
		d = d - CH_ZERO;
		if (d >= {2'b00, sc_base}) begin
			give_number(cfg_default, 1'b1);
		end else begin
			sc_acc = sc_acc * {58'd0, sc_base} + {56'd0, d};
			sc_phase = PH_DIGITS;
		end
	endtask

	task automatic open_number(input logic [7:0] c);
		if (c < CH_ZERO) begin
			give_number(cfg_default, 1'b1);
		end else if (c == CH_ZERO) begin
			sc_phase = PH_ZERO;
		end else begin
			sc_base = (cfg_base != 0) ? cfg_base : BASE_DEC;
			take_digit(c);
		end
	endtask

	task automatic scan_char(input logic [7:0] c, input logic first);
		if (first) begin
			sc_phase = PH_LEAD;
			sc_neg = 1'b0;
			sc_base = '0;
			sc_acc = '0;
		end
		case (sc_phase)
			PH_LEAD: begin
				if (c == CH_SPACE || c == CH_TAB) begin
				end else if (c < CH_SPACE) begin
					give_number(cfg_default, 1'b1);
				end else if (c == CH_MINUS) begin
					sc_neg = 1'b1;
					sc_phase = PH_SIGNED;
				end else if (c == CH_PLUS) begin
					sc_phase = PH_SIGNED;
				end else begin
					open_number(c);
				end
			end
			PH_SIGNED: open_number(c);
			PH_ZERO: begin
				if (c < CH_ZERO) begin
					sc_acc = '0;
					close_number();
				end else begin
					sc_base = (cfg_base != 0) ? cfg_base : BASE_OCT;
					if (c == CH_LC_X || c == CH_UC_X) begin
						sc_base = BASE_HEX;
						sc_phase = PH_PREFIXED;
					end else if (c == CH_LC_B || c == CH_UC_B) begin
						sc_base = BASE_BIN;
						sc_phase = PH_PREFIXED;
					end else if (c == CH_LC_O || c == CH_UC_O) begin
						sc_base = BASE_OCT;
						sc_phase = PH_PREFIXED;
					end else begin
						take_digit(c);
					end
				end
			end
			PH_PREFIXED: begin
				if (c < CH_ZERO)
					give_number(cfg_default, 1'b1);
				else
					take_digit(c);
			end
			PH_DIGITS: begin
				if (c < CH_ZERO)
					close_number();
				else
					take_digit(c);
			end
			default: sc_phase = PH_DONE;
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] c, input logic first);
		text_beat_t b;
		b.ch = c;
		b.first = first;
		pending_text.push_back(b);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], i == 0);
	endtask

	task automatic queue_part(input logic [7:0] c);
		queue_byte(c, !string_open);
		string_open = 1;
	endtask

	function automatic logic [7:0] digit_char(input int unsigned radix);
		int unsigned v;
		if ($urandom_range(19) == 0)
			return 8'($urandom_range(255, 48));
		v = $urandom_range((radix > 36 ? 36 : radix) - 1);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + 8'(v - 10);
	endfunction

	task automatic queue_random_string();
		int unsigned kind;
		int unsigned n;
		int unsigned radix;
		kind = $urandom_range(99);
		string_open = 0;
		if (kind < 12) begin
			n = $urandom_range(5, 1);
			repeat (n)
				queue_byte(8'($urandom), $urandom_range(3) == 0);
			return;
		end
		repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0)
			queue_part($urandom_range(1) ? CH_SPACE : CH_TAB);
		case ($urandom_range(3))
			0: queue_part(CH_MINUS);
			1: queue_part(CH_PLUS);
			default: ;
		endcase
		radix = 32'((cfg_base != 0) ? cfg_base : BASE_DEC);
		case ($urandom_range(5))
			0: begin
				queue_part(CH_ZERO);
				queue_part($urandom_range(1) ? CH_LC_X : CH_UC_X);
				radix = 32'(BASE_HEX);
			end
			1: begin
				queue_part(CH_ZERO);
				queue_part($urandom_range(1) ? CH_LC_B : CH_UC_B);
				radix = 32'(BASE_BIN);
			end
			2: begin
				queue_part(CH_ZERO);
				queue_part($urandom_range(1) ? CH_LC_O : CH_UC_O);
				radix = 32'(BASE_OCT);
			end
			3: begin
				queue_part(CH_ZERO);
				radix = 32'((cfg_base != 0) ? cfg_base : BASE_OCT);
			end
			default: ;
		endcase
		n = ($urandom_range(7) == 0) ? $urandom_range(24, 8) : $urandom_range(5, 1);
		if (kind < 20)
			n = $urandom_range(2);
		repeat (n)
			queue_part(digit_char(radix));
		if (kind < 28) begin
			// stray byte, or leave it open so the next string aborts it
			if ($urandom_range(1))
				queue_part(8'($urandom));
			else
				return;
		end
		queue_part(8'($urandom_range(47)));
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(3, 1))
				queue_part(8'($urandom));
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == REG_DEFAULT_VALUE)
			cfg_default = data;
		else
			cfg_base = data[BASE_WIDTH-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_text.size() != 0 || s_tvalid || awaited_numbers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		text_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				scan_char(s_tdata, s_tuser);
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (tx_hold || pending_text.size() == 0) begin
					s_tvalid <= 1'b0;
				end else begin
					nxt = pending_text.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.ch;
					s_tuser <= nxt.first;
					if (burst_left == 0)
						burst_left = $urandom_range(24, 1);
					burst_left--;
					if (burst_left == 0)
						gap_left = $urandom_range(1) ? 0 : $urandom_range(6, 1);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		number_t want;
		logic    rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_numbers.size() == 0) begin
					$error("unexpected result beat: parsed_value %h used_default %b",
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = awaited_numbers.pop_front();
					if (m_tdata !== want.value) begin
						$error("parsed_value: expected %h, actual %h", want.value, m_tdata);
						fail_count++;
					end
					if (m_tuser !== want.dflt) begin
						$error("used_default: expected %b, actual %b", want.dflt, m_tuser);
						fail_count++;
					end
				end
			end
			rx_tick++;
			if (rx_tick % 50 == 0)
				rx_mode = $urandom_range(3);
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(1));
				2: rdy = (rx_tick % 4 == 0);
				default: rdy = (rx_tick % 32) >= 20;
			endcase
			m_tready <= rdy;
		end
	end

	initial begin
		logic [63:0] dv;
		logic [5:0]  nb;
		int unsigned phase_bytes;
		int unsigned fill_mark;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		queue_text("0 ");
		queue_text("\t-0x7fF\n");
		queue_byte(8'h01, 1'b1);
		queue_text("+ ");
		queue_text("0b ");
		queue_text("12");
		queue_text("9 ");
		queue_text("077 ");
		queue_text("9a ");
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b1);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin dv = 64'h8000_0000_0000_0000; nb = 6'd0; end
				1: begin dv = 64'h7FFF_FFFF_FFFF_FFFF; nb = 6'd10; end
				2: begin dv = '1; nb = 6'd16; end
				3: begin dv = {$urandom, $urandom}; nb = 6'd36; end
				4: begin dv = {$urandom, $urandom}; nb = 6'd1; end
				5: begin dv = {$urandom, $urandom}; nb = 6'd63; end
				6: begin dv = {$urandom, $urandom}; nb = 6'd2; end
				default: begin dv = {$urandom, $urandom}; nb = 6'($urandom_range(63)); end
			endcase
			wait_idle();
			write_reg(REG_DEFAULT_VALUE, dv);
			write_reg(REG_NUMBER_BASE, {58'd0, nb});
			phase_bytes = 0;
			while (phase_bytes < 180) begin
				fill_mark = pending_text.size();
				queue_random_string();
				phase_bytes += pending_text.size() - fill_mark;
			end
			if (p == 2) begin
				while (pending_text.size() > 90)
					@(posedge clk);
				tx_hold <= 1'b1;
				@(posedge clk);
				while (s_tvalid || awaited_numbers.size() != 0)
					@(posedge clk);
				repeat (5) @(posedge clk);
				tx_hold <= 1'b0;
			end
			// leave the parser finished before the next register write
			queue_text("0 ");
		end

		wait_idle();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pitp_pkg.sv
hw/rtl/prefixed_integer_text_parser.sv
tb/sv/prefixed_integer_text_parser_test.sv
